// File: hw/rtl/fsvc_pkg.sv
// Shared constants and types of the first-seen-order value counter.
`default_nettype none

package fsvc_pkg;

  localparam int unsigned TABLE_DEPTH = 64;
  localparam int unsigned VALUE_WIDTH = 32;
  localparam int unsigned COUNT_WIDTH = 16;
  localparam int unsigned QUEUE_DEPTH = 2;

  typedef enum logic [0:0] {
    OP_ADD   = 1'b0,
    OP_CLOSE = 1'b1
  } op_e;

endpackage

`default_nettype wire

// File: hw/rtl/fsvc_queue.sv
// Small register queue that decouples the two sides of a transfer.
`default_nettype none

module fsvc_queue #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = fsvc_pkg::QUEUE_DEPTH
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [Width-1:0] data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic [Width-1:0]      data_o,
  output logic                  empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] entry_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/fsvc_engine.sv
// Back end: slot table search, count update and result emission.
`default_nettype none

module fsvc_engine #(
  parameter int unsigned TableDepth = fsvc_pkg::TABLE_DEPTH,
  parameter int unsigned ValueWidth = fsvc_pkg::VALUE_WIDTH,
  parameter int unsigned CountWidth = fsvc_pkg::COUNT_WIDTH
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cmd_valid_i,
  input  wire fsvc_pkg::op_e                cmd_op_i,
  input  wire logic signed [ValueWidth-1:0] cmd_value_i,
  output logic                              cmd_pop_o,
  input  wire logic                         res_full_i,
  output logic                              res_push_o,
  output logic signed [ValueWidth-1:0]      res_value_o,
  output logic [CountWidth-1:0]             res_count_o,
  output logic                              res_last_o,
  output logic                              res_empty_o,
  output logic                              res_overflow_o
);

  localparam int unsigned IdxW  = (TableDepth > 1) ? $clog2(TableDepth) : 1;
  localparam int unsigned UsedW = $clog2(TableDepth + 1);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_EMIT = 3'b100
  } state_e;

  state_e state_q, state_d;

  logic [ValueWidth-1:0] val_mem [TableDepth];
  logic [CountWidth-1:0] cnt_mem [TableDepth];

  logic [IdxW-1:0]       idx_q, idx_d;
  logic [UsedW-1:0]      used_q, used_d;
  logic                  flag_q, flag_d;
  logic [ValueWidth-1:0] key_q, key_d;
  logic [ValueWidth-1:0] rd_val_q;
  logic [CountWidth-1:0] rd_cnt_q;

  logic                  wr_val_en, wr_cnt_en;
  logic [IdxW-1:0]       wr_addr;
  logic [ValueWidth-1:0] wr_val;
  logic [CountWidth-1:0] wr_cnt;
  logic                  last_idx;
  logic                  table_full;
  logic [CountWidth-1:0] cnt_inc;

  assign last_idx   = ((UsedW'(idx_q) + UsedW'(1)) == used_q);
  assign table_full = (used_q == UsedW'(TableDepth));
  assign cnt_inc    = (rd_cnt_q == {CountWidth{1'b1}}) ? rd_cnt_q
                                                       : rd_cnt_q + CountWidth'(1);

  always_comb begin
    state_d        = state_q;
    idx_d          = '0;
    used_d         = used_q;
    flag_d         = flag_q;
    key_d          = key_q;
    cmd_pop_o      = 1'b0;
    res_push_o     = 1'b0;
    res_value_o    = '0;
    res_count_o    = '0;
    res_last_o     = 1'b0;
    res_empty_o    = 1'b0;
    res_overflow_o = 1'b0;
    wr_val_en      = 1'b0;
    wr_cnt_en      = 1'b0;
    wr_addr        = '0;
    wr_val         = cmd_value_i;
    wr_cnt         = CountWidth'(1);
    case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          case (cmd_op_i)
            fsvc_pkg::OP_ADD: begin
              cmd_pop_o = 1'b1;
              if (used_q == '0) begin
                wr_val_en = 1'b1;
                wr_cnt_en = 1'b1;
                used_d    = UsedW'(1);
              end else begin
                key_d   = cmd_value_i;
                state_d = ST_SCAN;
              end
            end
            fsvc_pkg::OP_CLOSE: begin
              if (used_q == '0) begin
                if (!res_full_i) begin
                  cmd_pop_o   = 1'b1;
                  res_push_o  = 1'b1;
                  res_last_o  = 1'b1;
                  res_empty_o = 1'b1;
                  flag_d      = 1'b0;
                end
              end else begin
                cmd_pop_o = 1'b1;
                state_d   = ST_EMIT;
              end
            end
            default: begin
              cmd_pop_o = 1'b1;
            end
          endcase
        end
      end
      ST_SCAN: begin
        wr_val = key_q;
        if (rd_val_q == key_q) begin
          wr_cnt_en = 1'b1;
          wr_addr   = idx_q;
          wr_cnt    = cnt_inc;
          state_d   = ST_IDLE;
        end else if (last_idx) begin
          if (table_full) begin
            flag_d = 1'b1;
          end else begin
            wr_val_en = 1'b1;
            wr_cnt_en = 1'b1;
            wr_addr   = used_q[IdxW-1:0];
            used_d    = used_q + UsedW'(1);
          end
          state_d = ST_IDLE;
        end else begin
          idx_d = idx_q + IdxW'(1);
        end
      end
      ST_EMIT: begin
        idx_d          = idx_q;
        res_value_o    = rd_val_q;
        res_count_o    = rd_cnt_q;
        res_last_o     = last_idx;
        res_overflow_o = flag_q;
        if (!res_full_i) begin
          res_push_o = 1'b1;
          if (last_idx) begin
            used_d  = '0;
            flag_d  = 1'b0;
            idx_d   = '0;
            state_d = ST_IDLE;
          end else begin
            idx_d = idx_q + IdxW'(1);
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
      used_q  <= '0;
      flag_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      used_q  <= used_d;
      flag_q  <= flag_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_val_en) begin
      val_mem[wr_addr] <= wr_val;
    end
    rd_val_q <= val_mem[idx_d];
  end

  always_ff @(posedge clk_i) begin
    if (wr_cnt_en) begin
      cnt_mem[wr_addr] <= wr_cnt;
    end
    rd_cnt_q <= cnt_mem[idx_d];
  end

endmodule

`default_nettype wire

// File: hw/rtl/first_seen_order_value_counter_unit.sv
// Top level of the first-seen-order value counter.
// Usage: items enter through a queue-style port (push, full). With func_i
// low, value_i is counted in the current set; with func_i high, the set is
// closed and its results are produced. Results leave through a queue-style
// port (empty, pop): one result per distinct value in order of first
// appearance, last_o on the final one, or a single empty_res_o marker for
// an empty set. overflow_o reports that a new value was dropped because
// the table was full.
// Timing: an add writes slot 0 directly when the table is empty and
// otherwise compares the occupied slots in order, until one matches,
// since the table is searched one slot per cycle through its single read
// port. A close emits the distinct values in order, pausing while the
// result queue is full. An item is held in the input queue registers
// while the engine is busy. Two-entry queues sit on both sides, so items
// are taken while results wait. When the receiver holds off pop, emission
// pauses and the input queue fills up, after which full stays high.
// Reset clears the table occupancy, the overflow flag and both queues;
// the block is ready in the first cycle after reset.
`default_nettype none

module first_seen_order_value_counter_unit #(
  parameter int unsigned TABLE_DEPTH = fsvc_pkg::TABLE_DEPTH,
  parameter int unsigned VALUE_WIDTH = fsvc_pkg::VALUE_WIDTH,
  parameter int unsigned COUNT_WIDTH = fsvc_pkg::COUNT_WIDTH
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          push,
  output logic                               full,
  input  wire logic                          func_i,
  input  wire logic signed [VALUE_WIDTH-1:0] value_i,
  output logic                               empty,
  input  wire logic                          pop,
  output logic signed [VALUE_WIDTH-1:0]      value_res_o,
  output logic [COUNT_WIDTH-1:0]             count_o,
  output logic                               last_o,
  output logic                               empty_res_o,
  output logic                               overflow_o
);

  localparam int unsigned CmdW = VALUE_WIDTH + 1;
  localparam int unsigned ResW = VALUE_WIDTH + COUNT_WIDTH + 3;

  logic [CmdW-1:0]               cmd_data;
  logic                          cmd_empty;
  logic                          cmd_pop;
  fsvc_pkg::op_e                 cmd_op;
  logic signed [VALUE_WIDTH-1:0] cmd_value;

  logic                          res_push;
  logic                          res_full;
  logic [ResW-1:0]               res_data;
  logic signed [VALUE_WIDTH-1:0] res_value;
  logic [COUNT_WIDTH-1:0]        res_count;
  logic                          res_last, res_empty, res_overflow;

  fsvc_queue #(
    .Width(CmdW),
    .Depth(fsvc_pkg::QUEUE_DEPTH)
  ) u_cmd_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i ({func_i, value_i}),
    .full_o (full),
    .pop_i  (cmd_pop),
    .data_o (cmd_data),
    .empty_o(cmd_empty)
  );

  assign cmd_op    = fsvc_pkg::op_e'(cmd_data[CmdW-1]);
  assign cmd_value = cmd_data[VALUE_WIDTH-1:0];

  fsvc_engine #(
    .TableDepth(TABLE_DEPTH),
    .ValueWidth(VALUE_WIDTH),
    .CountWidth(COUNT_WIDTH)
  ) u_engine (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_valid_i   (!cmd_empty),
    .cmd_op_i      (cmd_op),
    .cmd_value_i   (cmd_value),
    .cmd_pop_o     (cmd_pop),
    .res_full_i    (res_full),
    .res_push_o    (res_push),
    .res_value_o   (res_value),
    .res_count_o   (res_count),
    .res_last_o    (res_last),
    .res_empty_o   (res_empty),
    .res_overflow_o(res_overflow)
  );

  fsvc_queue #(
    .Width(ResW),
    .Depth(fsvc_pkg::QUEUE_DEPTH)
  ) u_res_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .data_i ({res_value, res_count, res_last, res_empty, res_overflow}),
    .full_o (res_full),
    .pop_i  (pop),
    .data_o (res_data),
    .empty_o(empty)
  );

  assign value_res_o = res_data[ResW-1 -: VALUE_WIDTH];
  assign count_o     = res_data[COUNT_WIDTH+2:3];
  assign last_o      = res_data[2];
  assign empty_res_o = res_data[1];
  assign overflow_o  = res_data[0];

`ifndef SYNTHESIS
  // The engine only produces a result when the result queue has room.
  assert property (@(posedge clk_i) disable iff (!rst_ni) res_push |-> !res_full)
    else $error("result produced while the result queue is full");

  // The engine only takes an item that is waiting in the input queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni) cmd_pop |-> !cmd_empty)
    else $error("item taken from an empty input queue");

  // An empty-set marker is always the final result of its set, with a zero count and no overflow.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (res_push && res_empty) |-> (res_last && !res_overflow && res_count == '0))
    else $error("malformed empty-set marker");

  // A closing item is only consumed together with a marker or when results follow.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (cmd_pop && cmd_op == fsvc_pkg::OP_CLOSE && !res_push) |=> !cmd_pop)
    else $error("closing item consumed without emission");
`endif

endmodule

`default_nettype wire

// File: sim/first_seen_order_value_counter_unit_tb.sv
// Self-checking testbench of the first-seen-order value counter unit.
module first_seen_order_value_counter_unit_tb;

  localparam int unsigned TABLE_DEPTH = fsvc_pkg::TABLE_DEPTH;
  localparam int unsigned VALUE_WIDTH = fsvc_pkg::VALUE_WIDTH;
  localparam int unsigned COUNT_WIDTH = fsvc_pkg::COUNT_WIDTH;
  localparam int unsigned CYCLE_LIMIT = 100000;
  localparam int unsigned LONG_POP_HOLD = 300;
  localparam int unsigned DRAIN_CYCLES = 100;
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
  localparam logic signed [VALUE_WIDTH-1:0] VALUE_MIN = {1'b1, {(VALUE_WIDTH - 1){1'b0}}};
  localparam logic signed [VALUE_WIDTH-1:0] VALUE_MAX = {1'b0, {(VALUE_WIDTH - 1){1'b1}}};

  typedef struct {
    fsvc_pkg::op_e                 func;
    logic signed [VALUE_WIDTH-1:0] value;
  } value_item_t;

  typedef struct {
    logic signed [VALUE_WIDTH-1:0] value;
    logic [COUNT_WIDTH-1:0]        count;
    logic                          last;
    logic                          empty_set;
    logic                          overflow;
  } count_result_t;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          push = 1'b0;
  logic                          full;
  logic                          func_i = fsvc_pkg::OP_ADD;
  logic signed [VALUE_WIDTH-1:0] value_i = '0;
  logic                          empty;
  logic                          pop = 1'b0;
  logic signed [VALUE_WIDTH-1:0] value_res_o;
  logic [COUNT_WIDTH-1:0]        count_o;
  logic                          last_o;
  logic                          empty_res_o;
  logic                          overflow_o;

  value_item_t   stream_items[$];
  count_result_t expected_counts[$];

  logic signed [VALUE_WIDTH-1:0] tally_value[TABLE_DEPTH];
  logic [COUNT_WIDTH-1:0]        tally_count[TABLE_DEPTH];
  int unsigned                   tally_used = 0;
  logic                          tally_dropped = 1'b0;

  bit          sender_quiet = 1'b0;
  bit          receiver_quiet = 1'b0;
  bit          hold_request = 1'b0;
  int unsigned send_idle = 0;
  int unsigned pop_hold = 0;
  int unsigned cycles = 0;
  int unsigned errors = 0;
  int unsigned items_queued = 0;
  int unsigned items_sent = 0;
  int unsigned sets_closed = 0;
  int unsigned results_seen = 0;
  int unsigned overflow_seen = 0;
  int unsigned full_cycles = 0;

  first_seen_order_value_counter_unit DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .func_i     (func_i),
    .value_i    (value_i),
    .empty      (empty),
    .pop        (pop),
    .value_res_o(value_res_o),
    .count_o    (count_o),
    .last_o     (last_o),
    .empty_res_o(empty_res_o),
    .overflow_o (overflow_o)
  );

  always #4 clk_i = ~clk_i;

  task automatic report_mismatch(input string msg);
    if (errors < 50) begin
      $display("mismatch at cycle %0d: %s", cycles, msg);
    end
    errors++;
  endtask

  // Updates the count table for one transferred item and, on a close,
  // queues the results that the set must produce.
  task automatic tally_item(input value_item_t it);
    count_result_t r;
    bit            hit;
    hit = 1'b0;
    if (it.func == fsvc_pkg::OP_ADD) begin
      for (int unsigned i = 0; i < tally_used; i++) begin
        if (!hit && tally_value[i] == it.value) begin
          hit = 1'b1;
          if (tally_count[i] != COUNT_MAX) begin
            tally_count[i]++;
          end
        end
      end
      if (!hit) begin
        if (tally_used < TABLE_DEPTH) begin
          tally_value[tally_used] = it.value;
          tally_count[tally_used] = COUNT_WIDTH'(1);
          tally_used++;
        end else begin
          tally_dropped = 1'b1;
        end
      end
    end else begin
      if (tally_used == 0) begin
        r.value = '0;
        r.count = '0;
        r.last = 1'b1;
        r.empty_set = 1'b1;
        r.overflow = tally_dropped;
        expected_counts.insert(expected_counts.size(), r);
      end else begin
        for (int unsigned i = 0; i < tally_used; i++) begin
          r.value = tally_value[i];
          r.count = tally_count[i];
          r.last = (i + 1 == tally_used);
          r.empty_set = 1'b0;
          r.overflow = tally_dropped;
          expected_counts.insert(expected_counts.size(), r);
        end
      end
      tally_used = 0;
      tally_dropped = 1'b0;
      sets_closed++;
    end
  endtask

  task automatic queue_item(input fsvc_pkg::op_e f, input logic signed [VALUE_WIDTH-1:0] v);
    value_item_t it;
    it.func = f;
    it.value = v;
    stream_items.insert(stream_items.size(), it);
    items_queued++;
  endtask

  task automatic queue_close;
    queue_item(fsvc_pkg::OP_CLOSE, $urandom);
  endtask

  task automatic wait_drained;
    while (stream_items.size() != 0 || push || expected_counts.size() != 0) begin
      @(negedge clk_i);
    end
  endtask

  // Random sets: mostly short ones drawn from a small pool so values repeat,
  // now and then an empty set or a long one of twenty to forty values.
  task automatic queue_random_sets(input int unsigned n_items);
    logic signed [VALUE_WIDTH-1:0] pool[6];
    int unsigned                   start;
    int unsigned                   len;
    start = items_queued;
    while (items_queued - start < n_items) begin
      foreach (pool[k]) begin
        pool[k] = $urandom;
      end
      case ($urandom_range(0, 15))
        0: len = 0;
        1: len = $urandom_range(20, 40);
        default: len = $urandom_range(1, 10);
      endcase
      for (int unsigned i = 0; i < len; i++) begin
        if ($urandom_range(0, 3) == 0) begin
          queue_item(fsvc_pkg::OP_ADD, $urandom);
        end else begin
          queue_item(fsvc_pkg::OP_ADD, pool[$urandom_range(0, 5)]);
        end
      end
      queue_close();
    end
  endtask

  always @(posedge clk_i) begin : driver
    bit taken;
    if (!rst_ni) begin
      push <= 1'b0;
    end else begin
      taken = push && !full;
      if (push && full) begin
        full_cycles++;
      end
      if (taken) begin
        tally_item(stream_items[0]);
        void'(stream_items.pop_front());
        items_sent++;
      end
      if (!push || taken) begin
        if (send_idle != 0) begin
          send_idle--;
          push <= 1'b0;
        end else if (stream_items.size() != 0 && !sender_quiet && $urandom_range(0, 11) == 0) begin
          send_idle = $urandom_range(0, 13);
          push <= 1'b0;
        end else if (stream_items.size() != 0) begin
          push <= 1'b1;
          func_i <= stream_items[0].func;
          value_i <= stream_items[0].value;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin : monitor
    count_result_t want;
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        results_seen++;
        if (overflow_o) overflow_seen++;
        if (expected_counts.size() == 0) begin
          report_mismatch($sformatf("result with nothing expected, value_res %0d", value_res_o));
        end else begin
          want = expected_counts.pop_front();
          if (value_res_o !== want.value)
            report_mismatch($sformatf("value_res %0d, expected %0d", value_res_o, want.value));
          if (count_o !== want.count)
            report_mismatch($sformatf("count %0d, expected %0d", count_o, want.count));
          if (last_o !== want.last)
            report_mismatch($sformatf("last %b, expected %b", last_o, want.last));
          if (empty_res_o !== want.empty_set)
            report_mismatch($sformatf("empty_res %b, expected %b", empty_res_o, want.empty_set));
          if (overflow_o !== want.overflow)
            report_mismatch($sformatf("overflow %b, expected %b", overflow_o, want.overflow));
        end
      end
      if (pop_hold != 0) begin
        pop_hold--;
        pop <= 1'b0;
      end else if (hold_request) begin
        hold_request = 1'b0;
        pop_hold = LONG_POP_HOLD - 1;
        pop <= 1'b0;
      end else if (!receiver_quiet && $urandom_range(0, 11) == 0) begin
        pop_hold = $urandom_range(0, 13);
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("status: fail");
      $finish;
    end
  end

  initial begin : stimulus
    logic signed [VALUE_WIDTH-1:0] base;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Empty set, extremes with repeats, a close right after a close,
    // and alternating bit patterns.
    queue_close();
    queue_item(fsvc_pkg::OP_ADD, VALUE_MIN);
    queue_item(fsvc_pkg::OP_ADD, VALUE_MAX);
    queue_item(fsvc_pkg::OP_ADD, 0);
    queue_item(fsvc_pkg::OP_ADD, -1);
    queue_item(fsvc_pkg::OP_ADD, VALUE_MAX);
    queue_item(fsvc_pkg::OP_ADD, VALUE_MIN);
    queue_item(fsvc_pkg::OP_ADD, VALUE_MIN);
    queue_item(fsvc_pkg::OP_ADD, 1);
    queue_close();
    queue_close();
    queue_item(fsvc_pkg::OP_ADD, 32'h5555_5555);
    queue_item(fsvc_pkg::OP_ADD, 32'hAAAA_AAAA);
    queue_item(fsvc_pkg::OP_ADD, 32'h5555_5555);
    queue_close();
    wait_drained();

    // A set that fills the table and then drops new values while known
    // values keep counting, then a short set that must show the flag cleared.
    base = $urandom;
    for (int unsigned k = 0; k < TABLE_DEPTH; k++) begin
      queue_item(fsvc_pkg::OP_ADD, base + 32'h0400_0001 * k);
    end
    queue_item(fsvc_pkg::OP_ADD, base + 32'h0400_0001 * 5);
    queue_item(fsvc_pkg::OP_ADD, base - 1);
    queue_item(fsvc_pkg::OP_ADD, base);
    queue_item(fsvc_pkg::OP_ADD, base - 2);
    queue_close();
    queue_item(fsvc_pkg::OP_ADD, base - 1);
    queue_item(fsvc_pkg::OP_ADD, base);
    queue_close();
    queue_close();
    wait_drained();

    // Receiver stalls for a long stretch while several sets keep coming.
    hold_request = 1'b1;
    for (int unsigned s = 0; s < 3; s++) begin
      for (int unsigned i = 0; i < 5; i++) begin
        queue_item(fsvc_pkg::OP_ADD, $urandom_range(0, 3) == 0 ? base : $urandom);
      end
      queue_close();
    end
    wait_drained();

    queue_random_sets(8);
    wait_drained();
    sender_quiet = 1'b1;
    receiver_quiet = 1'b1;
    queue_random_sets(8);
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d items in %0d sets, checked %0d results, input stalled %0d cycles.",
             items_sent, sets_closed, results_seen, full_cycles);
    $display("Results with overflow: %0d; mismatches: %0d.", overflow_seen, errors);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
